// ===== rtl/kis_pkg.sv =====
// ----------------------------------------------------------------------------
// kis_pkg: shared types and constants for the keyed insertion sorter
// Store depth, derived widths, the payload structs of both channels and the store entry.
// ----------------------------------------------------------------------------
package kis_pkg;

    // Store depth and derived widths
    localparam int MAX_ITEMS = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 5;

    // Input item
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } t_in;

    // Result item
    typedef struct packed {
        logic [VAL_W-1:0] sorted_value;
        logic [IDX_W-1:0] original_index;
        logic             last_out;
    } t_out;

    // One store entry: value and its arrival index
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
    } t_entry;

endpackage

// ===== rtl/keyed_insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// keyed_insertion_sorter: stable insertion sort of 32-bit keys with indices
//
// Input channel (i_valid / o_stall / i_data): one key per transfer; the
// transfer with last set closes the set. Each key is tagged with its arrival
// position and inserted into a sorted store of kis_pkg::MAX_ITEMS entries.
// Keys arriving while the store is full are dropped; a dropped closing key
// still closes the set.
// Insertion walks down the store one entry a cycle through a single compare
// and a single store port, shifting up each stored key strictly greater
// than the new one. o_stall is high for the whole insertion and the read-out.
// Output channel (o_valid / i_stall / o_data): after the closing item the
// store is read out in ascending order, each result by a store read then
// an output register load, last_out set on the final result. A stalled
// output holds its register; the read-out waits for it to empty. The next
// set may start while the final result still waits to be taken.
// Reset (synchronous, active low) empties the store by clearing its fill
// count; store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module keyed_insertion_sorter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  kis_pkg::t_in    i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output kis_pkg::t_out   o_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_EMIT_RD,
        S_EMIT_LOAD
    } t_state;

    t_state                        r_state, n_state;
    logic [kis_pkg::CNT_W-1:0]     r_fill, n_fill;
    logic [kis_pkg::CNT_W-1:0]     r_pos, n_pos;
    logic [kis_pkg::CNT_W-1:0]     r_k, n_k;
    logic [kis_pkg::VAL_W-1:0]     r_val, n_val;
    logic                          r_last, n_last;
    logic                          r_out_valid, n_out_valid;
    kis_pkg::t_out                 r_out, n_out;

    // Store and its registered read port
    kis_pkg::t_entry               r_mem [kis_pkg::MAX_ITEMS];
    kis_pkg::t_entry               r_rd;
    logic                          rd_en;
    logic [kis_pkg::ADDR_W-1:0]    rd_addr;
    logic                          wr_en;
    logic [kis_pkg::ADDR_W-1:0]    wr_addr;
    kis_pkg::t_entry               wr_data;

    logic [kis_pkg::CNT_W-1:0]     pos_dec;
    logic [kis_pkg::CNT_W-1:0]     k_inc;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign pos_dec = r_pos - kis_pkg::CNT_W'(1);
    assign k_inc   = r_k + kis_pkg::CNT_W'(1);

    // Sequencer: insertion walk and ordered read-out
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_k         = r_k;
        n_val       = r_val;
        n_last      = r_last;
        n_out_valid = r_out_valid & i_stall;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val  = i_data.value;
                    n_last = i_data.last;
                    if (r_fill < kis_pkg::CNT_W'(kis_pkg::MAX_ITEMS)) begin
                        n_pos   = r_fill;
                        n_state = S_INSERT;
                        if (r_fill != '0) begin
                            rd_en   = 1'b1;
                            rd_addr = kis_pkg::ADDR_W'(r_fill - kis_pkg::CNT_W'(1));
                        end
                    end else if (i_data.last) begin
                        // full store: key dropped, set still closes
                        n_k     = '0;
                        n_state = S_EMIT_RD;
                    end
                end
            end

            S_INSERT: begin
                if (r_pos != '0 && r_val < r_rd.value) begin
                    // shift the greater entry up one place
                    wr_en   = 1'b1;
                    wr_addr = kis_pkg::ADDR_W'(r_pos);
                    wr_data = r_rd;
                    n_pos   = pos_dec;
                    if (pos_dec != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = kis_pkg::ADDR_W'(pos_dec - kis_pkg::CNT_W'(1));
                    end
                end else begin
                    // place new key after any equal ones
                    wr_en         = 1'b1;
                    wr_addr       = kis_pkg::ADDR_W'(r_pos);
                    wr_data.value = r_val;
                    wr_data.index = kis_pkg::IDX_W'(r_fill);
                    n_fill        = r_fill + kis_pkg::CNT_W'(1);
                    n_k           = '0;
                    n_state       = r_last ? S_EMIT_RD : S_IDLE;
                end
            end

            S_EMIT_RD: begin
                rd_en   = 1'b1;
                rd_addr = kis_pkg::ADDR_W'(r_k);
                n_state = S_EMIT_LOAD;
            end

            S_EMIT_LOAD: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid          = 1'b1;
                    n_out.sorted_value   = r_rd.value;
                    n_out.original_index = r_rd.index;
                    n_out.last_out       = (k_inc == r_fill);
                    if (k_inc == r_fill) begin
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = k_inc;
                        n_state = S_EMIT_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pos       <= '0;
            r_k         <= '0;
            r_val       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pos       <= n_pos;
            r_k         <= n_k;
            r_val       <= n_val;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    // Store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

`ifndef ASSERT_OFF
    // fill count never passes the store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= kis_pkg::CNT_W'(kis_pkg::MAX_ITEMS))
        else $error("fill count above store depth");

    // insertion point never passes the fill count
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |-> (r_pos <= r_fill))
        else $error("insertion point beyond fill count");

    // read-out never addresses an empty entry
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_RD || r_state == S_EMIT_LOAD) |-> (r_k < r_fill))
        else $error("read-out index beyond fill count");

    // a final result empties the store for the next set
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_LOAD && (!r_out_valid || !i_stall) && k_inc == r_fill)
        |=> (r_fill == '0 && o_valid && o_data.last_out))
        else $error("final result did not empty the store");
`endif

endmodule
